FILE: rtl/diff_drive_go_to_goal_unit_defines.svh
// Assertion macros for the checker file of the go-to-goal unit.
`ifndef DIFF_DRIVE_GO_TO_GOAL_UNIT_DEFINES_SVH
`define DIFF_DRIVE_GO_TO_GOAL_UNIT_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define DDG_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on every clock edge, reset included.
`define DDG_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/ddg_pkg.sv
// Types and constants of the go-to-goal unit.
package ddg_pkg;

  typedef enum logic [2:0] {
    REG_GOAL_X        = 3'd0,
    REG_GOAL_Y        = 3'd1,
    REG_ARRIVE_RADIUS = 3'd2,
    REG_SPEED_GAIN    = 3'd3,
    REG_TURN_GAIN     = 3'd4,
    REG_MAX_SPEED     = 3'd5,
    REG_MAX_TURN_RATE = 3'd6,
    REG_TRACK_WIDTH   = 3'd7
  } cfg_reg_t;

  localparam int CORDIC_STEPS = 16;
  localparam int XW = 28;  // rotation datapath width
  localparam int VW = 29;  // vectoring datapath width
  localparam int ZW = 20;  // angle width, Q.16 radians

  typedef logic signed [ZW-1:0] angle_t;

  localparam angle_t HALF_PI = 20'sd102944;
  localparam logic [15:0] INV_K = 16'd39797;
  localparam logic signed [16:0] BEAR_MAX = 17'sd25735;
  localparam logic signed [16:0] BEAR_MIN = -17'sd25736;
  localparam logic signed [21:0] OUT_MAX = 22'sd131071;
  localparam logic signed [21:0] OUT_MIN = -22'sd131072;

  localparam angle_t ATAN_TAB [CORDIC_STEPS] = '{
    20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
    20'sd8, 20'sd4, 20'sd2
  };

endpackage

FILE: rtl/ddg_in_if.sv
// Pose channel: valid, ready and one pose item.
interface ddg_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pose_x;
  logic signed [15:0] pose_y;
  logic signed [15:0] heading;

  modport source (output valid, pose_x, pose_y, heading, input ready);
  modport sink (input valid, pose_x, pose_y, heading, output ready);
endinterface

FILE: rtl/ddg_out_if.sv
// Wheel speed channel: valid, ready and one result item.
interface ddg_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] left_speed;
  logic signed [17:0] right_speed;
  logic               arrived;

  modport source (output valid, left_speed, right_speed, arrived, input ready);
  modport sink (input valid, left_speed, right_speed, arrived, output ready);
endinterface

FILE: rtl/diff_drive_go_to_goal_unit.sv
// Go-to-goal steering for a differential drive: pose items in, wheel speed items out.
// The unit takes one pose item per clock while the pipeline is not stalled and returns
// one wheel speed item per pose from its 40-stage pipeline: two 16-stage CORDIC chains
// (one rotating the goal offset into the robot frame, one taking its bearing) plus
// the multiply and saturate stages around them. Each stage holds its item while the
// stage after it is full and stalled, so empty stages still fill while a result waits
// at the output. Each configuration register is read by the stage that uses it, so a
// write can also affect items already in the pipeline.
module diff_drive_go_to_goal_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  ddg_in_if.sink              in_ch,
  ddg_out_if.source           out_ch
);

  localparam int ST_ROT0 = 2;
  localparam int ST_VPRE = 18;
  localparam int ST_VEC0 = 19;
  localparam int ST_BEAR = 35;
  localparam int ST_VEL  = 36;
  localparam int ST_OMG  = 37;
  localparam int ST_HALF = 38;
  localparam int ST_OUT  = 39;
  localparam int NS      = 40;
  localparam int NC      = ddg_pkg::CORDIC_STEPS;
  localparam int XW      = ddg_pkg::XW;
  localparam int VW      = ddg_pkg::VW;
  localparam int ZW      = ddg_pkg::ZW;

  // Configuration registers.
  logic signed [15:0] goal_x_r, goal_y_r;
  logic [14:0]        arrive_radius_r;
  logic [15:0]        speed_gain_r, turn_gain_r, max_speed_r, max_turn_rate_r;
  logic [11:0]        track_width_r;
  logic [29:0]        rad_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r        <= 16'sd1792;
      goal_y_r        <= 16'sd896;
      arrive_radius_r <= 15'd5;
      speed_gain_r    <= 16'd3277;
      turn_gain_r     <= 16'd6144;
      max_speed_r     <= 16'd2458;
      max_turn_rate_r <= 16'd8192;
      track_width_r   <= 12'd128;
      rad_sq_r        <= 30'd25;
    end else begin
      rad_sq_r <= arrive_radius_r * arrive_radius_r;
      if (cfg_we) begin
        case (ddg_pkg::cfg_reg_t'(cfg_index))
          ddg_pkg::REG_GOAL_X:        goal_x_r        <= cfg_data;
          ddg_pkg::REG_GOAL_Y:        goal_y_r        <= cfg_data;
          ddg_pkg::REG_ARRIVE_RADIUS: arrive_radius_r <= cfg_data[14:0];
          ddg_pkg::REG_SPEED_GAIN:    speed_gain_r    <= cfg_data;
          ddg_pkg::REG_TURN_GAIN:     turn_gain_r     <= cfg_data;
          ddg_pkg::REG_MAX_SPEED:     max_speed_r     <= cfg_data;
          ddg_pkg::REG_MAX_TURN_RATE: max_turn_rate_r <= cfg_data;
          ddg_pkg::REG_TRACK_WIDTH:   track_width_r   <= cfg_data[11:0];
          default: ;
        endcase
      end
    end
  end

  // Stage valid bits and per-stage advance: a stage loads when it is empty or moves on.
  logic [NS-1:0] vld_r;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !vld_r[NS-1] || out_ch.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_ch.valid;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign in_ch.ready = adv[0];

  // Stage 0: goal offset and the rotation angle.
  logic signed [16:0] dx_r, dy_r, dx_nxt, dy_nxt;
  logic signed [ZW-1:0] r0_r;
  logic [ST_BEAR-1:0] zr_r;
  logic [NS-1:ST_ROT0] arr_r;

  assign dx_nxt = 17'(goal_x_r) - 17'(in_ch.pose_x);
  assign dy_nxt = 17'(goal_y_r) - 17'(in_ch.pose_y);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      r0_r    <= 20'sd0 - ZW'(signed'({in_ch.heading, 3'b000}));
      zr_r[0] <= (dx_nxt == 17'sd0) && (dy_nxt == 17'sd0);
    end
  end

  // Flags that ride along with each item.
  always_ff @(posedge clk) begin
    for (int k = 1; k < ST_BEAR; k++) begin
      if (adv[k]) zr_r[k] <= zr_r[k-1];
    end
    for (int k = ST_ROT0 + 1; k < NS; k++) begin
      if (adv[k]) arr_r[k] <= arr_r[k-1];
    end
  end

  // Stage 1: quarter-turn pre-rotation and the squared distance terms.
  logic signed [XW-1:0] rx_r [NC+1];
  logic signed [XW-1:0] ry_r [NC+1];
  logic signed [ZW-1:0] rz_r [NC+1];
  logic signed [XW-1:0] px, py;
  logic signed [ZW-1:0] pr;
  logic signed [33:0]   sqx_full, sqy_full;
  logic [32:0]          sqx_r, sqy_r;

  always_comb begin
    logic signed [XW-1:0] t;
    t  = '0;
    px = XW'(signed'({dx_r, 8'b0}));
    py = XW'(signed'({dy_r, 8'b0}));
    pr = r0_r;
    for (int k = 0; k < 3; k++) begin
      if (pr > ddg_pkg::HALF_PI) begin
        t  = px;
        px = -py;
        py = t;
        pr = pr - ddg_pkg::HALF_PI;
      end else if (pr < -ddg_pkg::HALF_PI) begin
        t  = px;
        px = py;
        py = -t;
        pr = pr + ddg_pkg::HALF_PI;
      end
    end
  end

  assign sqx_full = dx_r * dx_r;
  assign sqy_full = dy_r * dy_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      rx_r[0] <= px;
      ry_r[0] <= py;
      rz_r[0] <= pr;
      sqx_r   <= sqx_full[32:0];
      sqy_r   <= sqy_full[32:0];
    end
  end

  // Arrival test sits beside the first rotation step.
  always_ff @(posedge clk) begin
    if (adv[ST_ROT0]) begin
      arr_r[ST_ROT0] <= (34'(sqx_r) + 34'(sqy_r)) < 34'(rad_sq_r);
    end
  end

  // Rotation CORDIC, one step per stage.
  for (genvar k = 0; k < NC; k++) begin : g_rot
    always_ff @(posedge clk) begin
      if (adv[ST_ROT0+k]) begin
        if (!rz_r[k][ZW-1]) begin
          rx_r[k+1] <= rx_r[k] - (ry_r[k] >>> k);
          ry_r[k+1] <= ry_r[k] + (rx_r[k] >>> k);
          rz_r[k+1] <= rz_r[k] - ddg_pkg::ATAN_TAB[k];
        end else begin
          rx_r[k+1] <= rx_r[k] + (ry_r[k] >>> k);
          ry_r[k+1] <= ry_r[k] - (rx_r[k] >>> k);
          rz_r[k+1] <= rz_r[k] + ddg_pkg::ATAN_TAB[k];
        end
      end
    end
  end

  // Forward component scaled by 1/K, and pre-rotation for the bearing.
  logic signed [XW+17:0] fp_r;
  logic signed [XW-1:0]  fw_r [NC];
  logic signed [VW-1:0]  vx_r [NC+1];
  logic signed [VW-1:0]  vy_r [NC+1];
  logic signed [ZW-1:0]  vz_r [NC+1];
  logic signed [VW-1:0]  ex, ey;

  assign ex = VW'(rx_r[NC]);
  assign ey = VW'(ry_r[NC]);

  always_ff @(posedge clk) begin
    if (adv[ST_VPRE]) begin
      fp_r <= rx_r[NC] * signed'({2'b00, ddg_pkg::INV_K});
      if (ex[VW-1] && (ey > 0)) begin
        vx_r[0] <= ey;
        vy_r[0] <= -ex;
        vz_r[0] <= ddg_pkg::HALF_PI;
      end else if (ex[VW-1]) begin
        vx_r[0] <= -ey;
        vy_r[0] <= ex;
        vz_r[0] <= -ddg_pkg::HALF_PI;
      end else begin
        vx_r[0] <= ex;
        vy_r[0] <= ey;
        vz_r[0] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_VEC0]) fw_r[0] <= XW'(fp_r >>> 16);
    for (int k = 1; k < NC; k++) begin
      if (adv[ST_VEC0+k]) fw_r[k] <= fw_r[k-1];
    end
  end

  // Vectoring CORDIC, one step per stage.
  for (genvar k = 0; k < NC; k++) begin : g_vec
    always_ff @(posedge clk) begin
      if (adv[ST_VEC0+k]) begin
        if (vy_r[k] > 0) begin
          vx_r[k+1] <= vx_r[k] + (vy_r[k] >>> k);
          vy_r[k+1] <= vy_r[k] - (vx_r[k] >>> k);
          vz_r[k+1] <= vz_r[k] + ddg_pkg::ATAN_TAB[k];
        end else begin
          vx_r[k+1] <= vx_r[k] - (vy_r[k] >>> k);
          vy_r[k+1] <= vy_r[k] + (vx_r[k] >>> k);
          vz_r[k+1] <= vz_r[k] - ddg_pkg::ATAN_TAB[k];
        end
      end
    end
  end

  // Bearing in Q3.13 and the speed product.
  logic signed [16:0] bsh;
  logic signed [15:0] bear_r;
  logic signed [XW+16:0] sp_r;
  logic fpos_r;

  assign bsh = 17'((vz_r[NC] + 20'sd4) >>> 3);

  always_ff @(posedge clk) begin
    if (adv[ST_BEAR]) begin
      if (zr_r[ST_BEAR - 1]) begin
        bear_r <= '0;
      end else if (bsh > ddg_pkg::BEAR_MAX) begin
        bear_r <= 16'(ddg_pkg::BEAR_MAX);
      end else if (bsh < ddg_pkg::BEAR_MIN) begin
        bear_r <= 16'(ddg_pkg::BEAR_MIN);
      end else begin
        bear_r <= 16'(bsh);
      end
      sp_r   <= fw_r[NC-1] * signed'({1'b0, speed_gain_r});
      fpos_r <= fw_r[NC-1] > 0;
    end
  end

  // Forward speed and the turn product.
  logic signed [XW:0]  sp_sh;
  logic [15:0]         v36_r, v37_r, v38_r;
  logic signed [32:0]  omp_r;

  assign sp_sh = (XW+1)'(sp_r >>> 16);

  always_ff @(posedge clk) begin
    if (adv[ST_VEL]) begin
      if (!fpos_r) begin
        v36_r <= '0;
      end else if (sp_sh > signed'((XW+1)'(max_speed_r))) begin
        v36_r <= max_speed_r;
      end else begin
        v36_r <= 16'(sp_sh);
      end
      omp_r <= bear_r * signed'({1'b0, turn_gain_r});
    end
  end

  // Turn rate clamp.
  logic signed [19:0] om_sh;
  logic signed [16:0] om_r;

  assign om_sh = 20'(omp_r >>> 13);

  always_ff @(posedge clk) begin
    if (adv[ST_OMG]) begin
      v37_r <= v36_r;
      if (om_sh > signed'({4'b0, max_turn_rate_r})) begin
        om_r <= signed'({1'b0, max_turn_rate_r});
      end else if (om_sh < -signed'({4'b0, max_turn_rate_r})) begin
        om_r <= -signed'({1'b0, max_turn_rate_r});
      end else begin
        om_r <= 17'(om_sh);
      end
    end
  end

  // Half the wheel speed difference.
  logic signed [29:0] hp_r;

  always_ff @(posedge clk) begin
    if (adv[ST_HALF]) begin
      v38_r <= v37_r;
      hp_r  <= om_r * signed'({1'b0, track_width_r});
    end
  end

  // Output stage: wheel speeds with saturation.
  logic signed [21:0] half_w, lsum, rsum;
  logic signed [17:0] left_r, right_r;

  assign half_w = 22'(hp_r >>> 9);
  assign lsum   = signed'(22'(v38_r)) - half_w;
  assign rsum   = signed'(22'(v38_r)) + half_w;

  always_ff @(posedge clk) begin
    if (adv[ST_OUT]) begin
      if (arr_r[ST_HALF]) begin
        left_r  <= '0;
        right_r <= '0;
      end else begin
        left_r  <= (lsum > ddg_pkg::OUT_MAX) ? 18'(ddg_pkg::OUT_MAX) :
                   (lsum < ddg_pkg::OUT_MIN) ? 18'(ddg_pkg::OUT_MIN) : 18'(lsum);
        right_r <= (rsum > ddg_pkg::OUT_MAX) ? 18'(ddg_pkg::OUT_MAX) :
                   (rsum < ddg_pkg::OUT_MIN) ? 18'(ddg_pkg::OUT_MIN) : 18'(rsum);
      end
    end
  end

  assign out_ch.valid       = vld_r[NS-1];
  assign out_ch.left_speed  = left_r;
  assign out_ch.right_speed = right_r;
  assign out_ch.arrived     = arr_r[ST_OUT];

endmodule

FILE: rtl/ddg_chk.sv
// Port-level checker for the go-to-goal unit and its bind.
`include "diff_drive_go_to_goal_unit_defines.svh"

module ddg_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [17:0] out_left,
  input logic signed [17:0] out_right,
  input logic               out_arrived
);

  // A stalled result item holds its value.
  `DDG_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right) && $stable(out_arrived), "stalled result changed")

  // An arrived item always carries zero wheel speeds.
  `DDG_ASSERT_CLK(a_arrived_zero, out_valid && out_arrived |-> out_left == 18'sd0 && out_right == 18'sd0, "arrived item with nonzero speed")

  // With the output draining, the pipeline always takes a new item.
  `DDG_ASSERT_CLK(a_ready_flow, out_ready |-> in_ready, "input blocked while output drains")

  // Reset empties the pipeline.
  `DDG_ASSERT_ANY(a_reset_empty, !rst_n |=> !out_valid, "result item after reset")

endmodule

bind diff_drive_go_to_goal_unit ddg_chk u_ddg_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_left    (out_ch.left_speed),
  .out_right   (out_ch.right_speed),
  .out_arrived (out_ch.arrived)
);

FILE: verif/ddg_tb_pkg.sv
`timescale 1ns / 100ps
// Goal tracker class that predicts wheel speed items and checks the unit's results.
package ddg_tb_pkg;

  typedef struct {
    logic signed [17:0] left_speed;
    logic signed [17:0] right_speed;
    logic               arrived;
  } wheel_cmd_t;

  class goal_tracker;
    longint gx, gy, radius, sgain, tgain, vmax, wmax, track;
    wheel_cmd_t pending[$];
    int errors;

    function new();
      gx = 1792; gy = 896; radius = 5; sgain = 3277; tgain = 6144;
      vmax = 2458; wmax = 8192; track = 128; errors = 0;
    endfunction

    function void set_reg(ddg_pkg::cfg_reg_t idx, logic [15:0] val);
      case (idx)
        ddg_pkg::REG_GOAL_X:        gx = longint'($signed(val));
        ddg_pkg::REG_GOAL_Y:        gy = longint'($signed(val));
        ddg_pkg::REG_ARRIVE_RADIUS: radius = val[14:0];
        ddg_pkg::REG_SPEED_GAIN:    sgain = val;
        ddg_pkg::REG_TURN_GAIN:     tgain = val;
        ddg_pkg::REG_MAX_SPEED:     vmax = val;
        ddg_pkg::REG_MAX_TURN_RATE: wmax = val;
        ddg_pkg::REG_TRACK_WIDTH:   track = val[11:0];
        default: ;
      endcase
    endfunction

    function longint lim(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Arithmetic shifts on longint floor toward minus infinity.
    function void note_pose(logic signed [15:0] px, logic signed [15:0] py,
                            logic signed [15:0] hd);
      longint dx, dy, x, y, r, z, t, xs, ys, fwd, bear, v, w, half;
      wheel_cmd_t c;
      dx = gx - px;
      dy = gy - py;
      c.arrived = 0;
      if (dx * dx + dy * dy < radius * radius) begin
        c.left_speed = 0; c.right_speed = 0; c.arrived = 1;
        pending.push_back(c);
        return;
      end
      fwd = 0; bear = 0;
      if (dx != 0 || dy != 0) begin
        x = dx * 256; y = dy * 256; r = -longint'(hd) * 8;
        for (int k = 0; k < 3; k++) begin
          if (r > ddg_pkg::HALF_PI) begin
            t = x; x = -y; y = t; r -= ddg_pkg::HALF_PI;
          end else if (r < -ddg_pkg::HALF_PI) begin
            t = x; x = y; y = -t; r += ddg_pkg::HALF_PI;
          end
        end
        for (int i = 0; i < ddg_pkg::CORDIC_STEPS; i++) begin
          xs = x >>> i; ys = y >>> i;
          if (r >= 0) begin
            x = x - ys; y = y + xs; r -= ddg_pkg::ATAN_TAB[i];
          end else begin
            x = x + ys; y = y - xs; r += ddg_pkg::ATAN_TAB[i];
          end
        end
        // The constant is unsigned, so it is widened to a signed operand first.
        fwd = (x * longint'(ddg_pkg::INV_K)) >>> 16;
        z = 0;
        if (x < 0) begin
          if (y > 0) begin
            t = x; x = y; y = -t; z = ddg_pkg::HALF_PI;
          end else begin
            t = x; x = -y; y = t; z = -ddg_pkg::HALF_PI;
          end
        end
        for (int i = 0; i < ddg_pkg::CORDIC_STEPS; i++) begin
          xs = x >>> i; ys = y >>> i;
          if (y > 0) begin
            x = x + ys; y = y - xs; z += ddg_pkg::ATAN_TAB[i];
          end else begin
            x = x - ys; y = y + xs; z -= ddg_pkg::ATAN_TAB[i];
          end
        end
        bear = lim((z + 4) >>> 3, -25736, 25735);
      end
      v = (fwd <= 0) ? 0 : lim((sgain * fwd) >>> 16, 0, vmax);
      w = lim((tgain * bear) >>> 13, -wmax, wmax);
      half = (w * track) >>> 9;
      c.left_speed = 18'(lim(v - half, -131072, 131071));
      c.right_speed = 18'(lim(v + half, -131072, 131071));
      pending.push_back(c);
    endfunction

    function void check_cmd(wheel_cmd_t got);
      wheel_cmd_t e;
      if (pending.size() == 0) begin
        $error("unexpected wheel speed item");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.left_speed !== e.left_speed) begin
        $error("left_speed expected %0d got %0d", e.left_speed, got.left_speed);
        errors++;
      end
      if (got.right_speed !== e.right_speed) begin
        $error("right_speed expected %0d got %0d", e.right_speed, got.right_speed);
        errors++;
      end
      if (got.arrived !== e.arrived) begin
        $error("arrived expected %0d got %0d", e.arrived, got.arrived);
        errors++;
      end
    endfunction
  endclass
endpackage

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Top testbench of the go-to-goal unit: stimulus, idling and end of run.
module tb_top;

  localparam int LATENCY = 40;
  localparam longint CYCLE_LIMIT = 600000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  longint      cycles;

  ddg_in_if  in_ch ();
  ddg_out_if out_ch ();

  ddg_tb_pkg::goal_tracker tracker = new();

  diff_drive_go_to_goal_unit dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Result side: random stalls with stretches of constant ready.
  initial begin
    int mode;
    out_ch.ready = 0;
    mode = 0;
    @(posedge clk);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 2);
      if (mode == 0) out_ch.ready <= 1'b1;
      else if (mode == 1) out_ch.ready <= ($urandom_range(0, 3) != 0);
      else out_ch.ready <= (gap_len() == 0);
    end
  end

  always @(posedge clk) begin
    ddg_tb_pkg::wheel_cmd_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.left_speed = out_ch.left_speed;
      got.right_speed = out_ch.right_speed;
      got.arrived = out_ch.arrived;
      tracker.check_cmd(got);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(ddg_pkg::cfg_reg_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.set_reg(idx, val);
  endtask

  task automatic drain();
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // Presents one pose with an optional leading gap and waits for acceptance.
  task automatic send_pose(logic [15:0] px, logic [15:0] py, logic [15:0] hd,
                           bit idle_first);
    int g;
    g = idle_first ? gap_len() : 0;
    if (g > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.pose_x <= px;
    in_ch.pose_y <= py;
    in_ch.heading <= hd;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_pose(px, py, hd);
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  function automatic logic [15:0] any_heading();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 51472)) - 25736);
  endfunction

  task automatic random_phase(int n);
    logic signed [15:0] gxv, gyv;
    int spread;
    gxv = 16'(tracker.gx);
    gyv = 16'(tracker.gy);
    for (int i = 0; i < n; i++) begin
      spread = ($urandom_range(0, 3) == 0) ? 16 : ($urandom_range(0, 1) ? 2048 : 32768);
      if (spread == 32768)
        send_pose(16'($urandom), 16'($urandom), any_heading(), 1);
      else
        send_pose(16'(gxv + $signed($urandom_range(0, 2 * spread)) - spread),
                  16'(gyv + $signed($urandom_range(0, 2 * spread)) - spread),
                  any_heading(), 1);
    end
    end_burst();
  endtask

  initial begin
    rst_n = 0;
    cycles = 0;
    cfg_we = 0;
    cfg_index = ddg_pkg::REG_GOAL_X;
    cfg_data = 0;
    in_ch.valid = 0;
    in_ch.pose_x = 0;
    in_ch.pose_y = 0;
    in_ch.heading = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed poses with reset settings: on goal, inside radius, extremes,
    // goal straight behind, and headings beyond pi.
    send_pose(16'd1792, 16'd896, 16'd0, 0);
    send_pose(16'd1794, 16'd897, 16'd0, 0);
    send_pose(16'h8000, 16'h8000, 16'h8000, 0);
    send_pose(16'h7fff, 16'h7fff, 16'h7fff, 0);
    send_pose(16'h8000, 16'h7fff, 16'd25736, 0);
    send_pose(16'h7fff, 16'h8000, -16'sd25736, 0);
    send_pose(16'd2048, 16'd896, 16'd0, 0);
    send_pose(16'd0, 16'd896, 16'd25736, 0);
    send_pose(16'd0, 16'd896, -16'sd25736, 0);
    send_pose(16'd1792, 16'd0, 16'd12868, 0);
    send_pose(16'd1792, 16'd2000, -16'sd12868, 0);
    send_pose(16'd0, 16'd0, 16'hffff, 0);
    end_burst();
    drain();

    // Pose on goal with zero radius, extreme registers.
    write_reg(ddg_pkg::REG_ARRIVE_RADIUS, 16'd0);
    write_reg(ddg_pkg::REG_GOAL_X, 16'h8000);
    write_reg(ddg_pkg::REG_GOAL_Y, 16'h7fff);
    write_reg(ddg_pkg::REG_SPEED_GAIN, 16'hffff);
    write_reg(ddg_pkg::REG_TURN_GAIN, 16'hffff);
    write_reg(ddg_pkg::REG_MAX_SPEED, 16'hffff);
    write_reg(ddg_pkg::REG_MAX_TURN_RATE, 16'hffff);
    write_reg(ddg_pkg::REG_TRACK_WIDTH, 16'hffff);
    send_pose(16'h8000, 16'h7fff, 16'd0, 0);
    send_pose(16'h7fff, 16'h8000, 16'd0, 0);
    send_pose(16'h7fff, 16'h8000, 16'd25736, 0);
    end_burst();
    random_phase(150);
    drain();

    // Zero caps, widest arrival radius and goal at the origin.
    write_reg(ddg_pkg::REG_MAX_SPEED, 16'd0);
    write_reg(ddg_pkg::REG_MAX_TURN_RATE, 16'd0);
    write_reg(ddg_pkg::REG_ARRIVE_RADIUS, 16'hffff);
    write_reg(ddg_pkg::REG_GOAL_X, 16'd0);
    write_reg(ddg_pkg::REG_GOAL_Y, 16'd0);
    random_phase(150);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(ddg_pkg::REG_GOAL_X, 16'($urandom));
      write_reg(ddg_pkg::REG_GOAL_Y, 16'($urandom));
      write_reg(ddg_pkg::REG_ARRIVE_RADIUS, 16'($urandom_range(0, 600)));
      write_reg(ddg_pkg::REG_SPEED_GAIN, 16'($urandom));
      write_reg(ddg_pkg::REG_TURN_GAIN, 16'($urandom));
      write_reg(ddg_pkg::REG_MAX_SPEED, 16'($urandom));
      write_reg(ddg_pkg::REG_MAX_TURN_RATE, 16'($urandom));
      write_reg(ddg_pkg::REG_TRACK_WIDTH, 16'($urandom));
      random_phase(200);
      drain();
    end

    if (tracker.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

FILE: files.f
+incdir+rtl
rtl/ddg_pkg.sv
rtl/ddg_in_if.sv
rtl/ddg_out_if.sv
rtl/diff_drive_go_to_goal_unit.sv
rtl/ddg_chk.sv
verif/ddg_tb_pkg.sv
verif/tb_top.sv
